### rtl/core/vlmr_pkg.sv
// ----------------------------------------------------------------------------
// Message ring package
// Shared sizes, request and status codes and payload types of the message ring.
// ----------------------------------------------------------------------------
package vlmr_pkg;

  localparam int BUFFER_BYTES  = 4096;
  localparam int HEADER_BYTES  = 8;
  localparam int MAX_MSG_BYTES = 64;

  localparam int POS_W  = $clog2(BUFFER_BYTES);
  localparam int FREE_W = POS_W + 1;
  localparam int LEN_W  = 7;

  // Request codes.
  localparam logic [1:0] REQ_SEND_START = 2'd0;
  localparam logic [1:0] REQ_SEND_BYTE  = 2'd1;
  localparam logic [1:0] REQ_RECEIVE    = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_ACCEPT   = 3'd1;
  localparam logic [2:0] ST_REFUSED  = 3'd2;
  localparam logic [2:0] ST_WRAPPED  = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_WRAPDONE = 3'd5;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [LEN_W-1:0] msg_len;
    logic [7:0]       data_byte;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic hdr;
    logic stream;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rx_direct;
    logic len_zero;
    logic rem_last;
  } sts_t;

endpackage

### rtl/core/vlmr_ctrl.sv
// ----------------------------------------------------------------------------
// Message ring controller
// Sequences the header read and the byte stream of a receive request.
// ----------------------------------------------------------------------------
module vlmr_ctrl
  import vlmr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] req_type,
  input  sts_t       sts,
  output logic       busy,
  output cmd_t       cmd
);

  typedef enum logic [1:0] {S_IDLE, S_HDR, S_STREAM} state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd.accept = start && !busy_r;
    cmd.hdr    = (state_r == S_HDR);
    cmd.stream = (state_r == S_STREAM);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept && req_type == REQ_RECEIVE && !sts.rx_direct) begin
          state_nxt = S_HDR;
        end
      end
      S_HDR: begin
        state_nxt = sts.len_zero ? S_IDLE : S_STREAM;
      end
      S_STREAM: begin
        if (sts.rem_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

### rtl/core/vlmr_dp.sv
// ----------------------------------------------------------------------------
// Message ring datapath
// Byte store, ring pointers, free count, wrap marker and result register.
// ----------------------------------------------------------------------------
module vlmr_dp
  import vlmr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  in_t  in_req,
  output sts_t sts,
  output logic out_valid,
  output out_t out_res
);

  localparam logic [POS_W-1:0]  HDR_POS  = POS_W'(HEADER_BYTES);
  localparam logic [FREE_W-1:0] HDR_FREE = FREE_W'(HEADER_BYTES);
  localparam logic [FREE_W-1:0] BUF_FREE = FREE_W'(BUFFER_BYTES);
  localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_MSG_BYTES);

  logic [7:0] byte_store_r [BUFFER_BYTES];
  logic [7:0] rdata_r;

  logic [POS_W-1:0]  head_r, head_nxt;
  logic [POS_W-1:0]  tail_r, tail_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic [POS_W-1:0]  wpos_r, wpos_nxt;
  logic [LEN_W-1:0]  owed_r, owed_nxt;
  logic              wrap_pend_r, wrap_pend_nxt;
  logic [POS_W-1:0]  wrap_at_r, wrap_at_nxt;
  logic [LEN_W-1:0]  wrap_credit_r, wrap_credit_nxt;
  logic [POS_W-1:0]  rd_pos_r, rd_pos_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic              we;
  logic [POS_W-1:0]  waddr;
  logic [7:0]        wdata;
  logic [POS_W-1:0]  rd_addr;

  logic [LEN_W-1:0]  in_len;
  logic [LEN_W-1:0]  hdr_len;
  logic [FREE_W-1:0] need;
  logic [FREE_W-1:0] room;
  logic              empty;
  logic              wrap_hit;
  logic [FREE_W-1:0] add_amt;
  logic [FREE_W:0]   add_sum;
  logic [FREE_W-1:0] free_added;
  logic [FREE_W-1:0] free_taken;

  assign in_len   = (in_req.msg_len > MAX_LEN) ? MAX_LEN : in_req.msg_len;
  assign hdr_len  = (rdata_r > 8'(MAX_LEN)) ? MAX_LEN : rdata_r[LEN_W-1:0];
  assign need     = FREE_W'(in_len) + HDR_FREE;
  assign room     = BUF_FREE - FREE_W'(head_r);
  assign empty    = (free_r >= BUF_FREE) || (head_r == tail_r);
  assign wrap_hit = wrap_pend_r && (tail_r == wrap_at_r);
  assign free_taken = (free_r > need) ? free_r - need : '0;

  assign sts.rx_direct = empty || wrap_hit;
  assign sts.len_zero  = (hdr_len == '0);
  assign sts.rem_last  = (rem_r == LEN_W'(1));

  // Saturating add to the free count; the amount depends on the step.
  always_comb begin
    if (cmd.accept) begin
      add_amt = FREE_W'(wrap_credit_r) + HDR_FREE;
    end else if (cmd.hdr) begin
      add_amt = HDR_FREE;
    end else begin
      add_amt = FREE_W'(len_r) + HDR_FREE;
    end
    add_sum    = {1'b0, free_r} + {1'b0, add_amt};
    free_added = (add_sum > {1'b0, BUF_FREE}) ? BUF_FREE : add_sum[FREE_W-1:0];
  end

  always_comb begin
    if (cmd.stream) begin
      rd_addr = rd_pos_r;
    end else if (cmd.hdr) begin
      rd_addr = tail_r + HDR_POS;
    end else begin
      rd_addr = tail_r;
    end
  end

  always_comb begin
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    free_nxt        = free_r;
    wpos_nxt        = wpos_r;
    owed_nxt        = owed_r;
    wrap_pend_nxt   = wrap_pend_r;
    wrap_at_nxt     = wrap_at_r;
    wrap_credit_nxt = wrap_credit_r;
    rd_pos_nxt      = rd_pos_r;
    rem_nxt         = rem_r;
    len_nxt         = len_r;
    out_valid_nxt   = 1'b0;
    out_nxt         = out_r;
    we              = 1'b0;
    waddr           = head_r;
    wdata           = 8'(in_len);

    if (cmd.accept) begin
      case (in_req.req_type)
        REQ_SEND_START: begin
          out_valid_nxt    = 1'b1;
          out_nxt.out_byte = 8'd0;
          out_nxt.last     = 1'b1;
          out_nxt.status   = ST_REFUSED;
          if (owed_r == '0) begin
            if (need >= room) begin
              if (tail_r != '0 && !wrap_pend_r) begin
                wrap_pend_nxt   = 1'b1;
                wrap_at_nxt     = head_r;
                wrap_credit_nxt = in_len;
                free_nxt        = free_taken;
                head_nxt        = '0;
                out_nxt.status  = ST_WRAPPED;
              end
            end else if (need + FREE_W'(1) < free_r) begin
              we             = 1'b1;
              free_nxt       = free_taken;
              wpos_nxt       = head_r + HDR_POS;
              owed_nxt       = in_len;
              out_nxt.status = ST_ACCEPT;
              if (in_len == '0) begin
                head_nxt = head_r + HDR_POS;
              end
            end
          end
        end
        REQ_SEND_BYTE: begin
          if (owed_r != '0) begin
            we       = 1'b1;
            waddr    = wpos_r;
            wdata    = in_req.data_byte;
            wpos_nxt = wpos_r + POS_W'(1);
            owed_nxt = owed_r - LEN_W'(1);
            if (owed_r == LEN_W'(1)) begin
              head_nxt = wpos_r + POS_W'(1);
            end
          end
        end
        REQ_RECEIVE: begin
          if (empty) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ST_EMPTY, out_byte: 8'd0, last: 1'b1};
          end else if (wrap_hit) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{status: ST_WRAPDONE, out_byte: 8'd0, last: 1'b1};
            free_nxt      = free_added;
            tail_nxt      = '0;
            wrap_pend_nxt = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (cmd.hdr) begin
      if (hdr_len == '0) begin
        tail_nxt = tail_r + HDR_POS;
        free_nxt = free_added;
      end else begin
        rem_nxt    = hdr_len;
        len_nxt    = hdr_len;
        rd_pos_nxt = tail_r + HDR_POS + POS_W'(1);
      end
    end else if (cmd.stream) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '{status: ST_DATA, out_byte: rdata_r, last: sts.rem_last};
      rem_nxt       = rem_r - LEN_W'(1);
      rd_pos_nxt    = rd_pos_r + POS_W'(1);
      if (sts.rem_last) begin
        tail_nxt = tail_r + HDR_POS + POS_W'(len_r);
        free_nxt = free_added;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      byte_store_r[waddr] <= wdata;
    end
    rdata_r <= byte_store_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      tail_r        <= '0;
      free_r        <= BUF_FREE;
      wpos_r        <= '0;
      owed_r        <= '0;
      wrap_pend_r   <= 1'b0;
      wrap_at_r     <= '0;
      wrap_credit_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      head_r        <= head_nxt;
      tail_r        <= tail_nxt;
      free_r        <= free_nxt;
      wpos_r        <= wpos_nxt;
      owed_r        <= owed_nxt;
      wrap_pend_r   <= wrap_pend_nxt;
      wrap_at_r     <= wrap_at_nxt;
      wrap_credit_r <= wrap_credit_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_pos_r <= rd_pos_nxt;
    rem_r    <= rem_nxt;
    len_r    <= len_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

### rtl/core/variable_length_message_ring_core.sv
// ----------------------------------------------------------------------------
// Variable-length message ring core
// Byte ring that stores length-prefixed messages and streams them back out.
// ----------------------------------------------------------------------------
// A request is taken on in_req at a rising edge where start is high and busy
// is low. Its type selects send start (reserve room and write the header),
// send byte (write one payload byte) or receive (stream one message).
// A send start gives one result on the cycle after the request: accepted,
// refused, or wrapped, which asks the producer to retry from the store start.
// Send byte requests give no result and can follow each other back to back.
// A receive that finds the store empty or consumes a wrap marker gives one
// result on the next cycle without raising busy. Otherwise busy is high while
// the header is read and the payload streams; one byte result appears per
// cycle once the header and then the first payload byte have been read,
// the final one marked last, all read through the single read port of the byte
// store. A zero-length message is read as a header alone and gives no
// result. Each result is shown for one cycle with out_valid high; the receiver
// must take it then, as it cannot stall the block.
// Reset (rst_n low, synchronous) empties the ring: pointers at zero, the free
// count at the full store size, no wrap marker. The store itself is not
// cleared; entries are only read after being written.
// ----------------------------------------------------------------------------
module variable_length_message_ring_core
  import vlmr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_req,
  output logic out_valid,
  output out_t out_res
);

  cmd_t cmd;
  sts_t sts;

  vlmr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_req.req_type),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd)
  );

  vlmr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .sts       (sts),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

`ifndef SYNTHESIS
  // Every result that is not a payload byte is the only result of its request.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status != ST_DATA |-> out_res.last)
    else $error("non-data result without last mark");

  // A send start always answers on the following cycle.
  a_start_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req.req_type == REQ_SEND_START |=> out_valid && out_res.last)
    else $error("send start gave no result");

  // A receive that must read the store holds the block busy.
  a_rx_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && in_req.req_type == REQ_RECEIVE && !sts.rx_direct |=> busy)
    else $error("streaming receive did not raise busy");

  // Payload bytes only come out while streaming or just after it.
  a_data_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status == ST_DATA |-> $past(cmd.stream))
    else $error("data result outside a stream");
`endif

endmodule
